### hw/rtl/tfd_pkg.sv
// Shared types and constants for the temperature frame deframer.
package tfd_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'h66;
    localparam logic [7:0] TAIL_FIRST  = 8'hDD;
    localparam logic [7:0] TAIL_SECOND = 8'hAA;
    localparam logic [14:0] TEMP_SCALE = 15'd100;

    // Byte positions within a frame.
    localparam logic [3:0] POS_HEADER    = 4'd0;
    localparam logic [3:0] POS_UNUSED    = 4'd1;
    localparam logic [3:0] POS_LAST_DATA = 4'd7;
    localparam logic [3:0] POS_TAIL1     = 4'd8;
    localparam logic [3:0] POS_TAIL2     = 4'd9;

    // Trailer skip phases.
    localparam logic [1:0] PH_NONE  = 2'd0;
    localparam logic [1:0] PH_ENDED = 2'd1;
    localparam logic [1:0] PH_DD    = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_GOOD    = 2'd0;
    localparam logic [1:0] ST_BADTAIL = 2'd1;
    localparam logic [1:0] ST_BADHEAD = 2'd2;

    typedef struct packed {
        logic        vld;
        logic [1:0]  status;
        logic [31:0] device_id;
        logic [14:0] temperature;
    } tfd_result_t;

endpackage

### hw/rtl/tfd_parser.sv
// Frame state and per-byte decode for the temperature frame deframer.
module tfd_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [7:0]          data_byte,
    output tfd_pkg::tfd_result_t res
);
    import tfd_pkg::*;

    logic [3:0]  pos_reg, pos_next;
    logic [47:0] payload_reg, payload_next;
    logic [7:0]  tail1_reg, tail1_next;
    logic [1:0]  phase_reg, phase_next;
    logic        halted_reg, halted_next;
    logic [14:0] temp_val;

    assign temp_val = 15'(payload_reg[15:8]) * TEMP_SCALE + 15'(payload_reg[7:0]);

    always_comb begin
        pos_next     = pos_reg;
        payload_next = payload_reg;
        tail1_next   = tail1_reg;
        phase_next   = phase_reg;
        halted_next  = halted_reg;
        res          = '0;
        if (step && !halted_reg) begin
            if (phase_reg == PH_DD) begin
                phase_next = PH_NONE;
                if (data_byte != TAIL_SECOND) begin
                    // The held DD was really a header, and a bad one.
                    halted_next = 1'b1;
                    pos_next    = POS_HEADER;
                    res.vld     = 1'b1;
                    res.status  = ST_BADHEAD;
                end
            end else if (phase_reg == PH_ENDED && data_byte == TAIL_FIRST) begin
                phase_next = PH_DD;
            end else begin
                phase_next = PH_NONE;
                case (pos_reg)
                    POS_HEADER: begin
                        if (data_byte != HEADER_BYTE) begin
                            halted_next = 1'b1;
                            res.vld     = 1'b1;
                            res.status  = ST_BADHEAD;
                        end else begin
                            pos_next = POS_UNUSED;
                        end
                    end
                    POS_UNUSED: begin
                        pos_next = pos_reg + 4'd1;
                    end
                    4'd2, 4'd3, 4'd4, 4'd5, 4'd6, POS_LAST_DATA: begin
                        payload_next = {payload_reg[39:0], data_byte};
                        pos_next     = pos_reg + 4'd1;
                    end
                    POS_TAIL1: begin
                        tail1_next = data_byte;
                        pos_next   = POS_TAIL2;
                    end
                    default: begin
                        pos_next   = POS_HEADER;
                        phase_next = PH_ENDED;
                        res.vld    = 1'b1;
                        if (tail1_reg != TAIL_FIRST || data_byte != TAIL_SECOND) begin
                            res.status = ST_BADTAIL;
                        end else begin
                            res.status      = ST_GOOD;
                            res.device_id   = payload_reg[47:16];
                            res.temperature = temp_val;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= POS_HEADER;
            phase_reg  <= PH_NONE;
            halted_reg <= 1'b0;
        end else begin
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            halted_reg <= halted_next;
        end
    end

    always_ff @(posedge aclk) begin
        payload_reg <= payload_next;
        tail1_reg   <= tail1_next;
    end

`ifndef SYNTHESIS
    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> !res.vld)
        else $error("result produced while halted");
    a_badhead_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.vld && res.status == ST_BADHEAD) |=> halted_reg)
        else $error("bad header did not halt the block");
    a_phase_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_NONE |-> pos_reg == POS_HEADER)
        else $error("trailer skip active in mid frame");
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_TAIL2)
        else $error("byte position out of range");
`endif

endmodule

### hw/rtl/tfd_out_stage.sv
// Result register for the temperature frame deframer.
module tfd_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  tfd_pkg::tfd_result_t res,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic [1:0]           m_status,
    output logic [31:0]          m_device_id,
    output logic [14:0]          m_temperature
);
    import tfd_pkg::*;

    logic        valid_reg;
    logic [1:0]  status_reg;
    logic [31:0] id_reg;
    logic [14:0] temp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load && res.vld) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && res.vld) begin
            status_reg <= res.status;
            id_reg     <= res.device_id;
            temp_reg   <= res.temperature;
        end
    end

    assign m_valid       = valid_reg;
    assign m_status      = status_reg;
    assign m_device_id   = id_reg;
    assign m_temperature = temp_reg;

endmodule

### hw/rtl/temperature_frame_deframer.sv
// Top level of the temperature frame deframer: input register, parser, result register.
//
//  Channel | Ports                                         | Role
//  --------+-----------------------------------------------+---------------------
//  input   | s_valid, s_ready, s_data_byte                 | received serial bytes
//  result  | m_valid, m_ready, m_status, m_device_id,      | readings and status
//          | m_temperature                                 |
//
// One byte per cycle is sustained while the result register is free or being read;
// an accepted byte is held in the input register, and its result, if any, is then
// loaded into the result register, from which it can be taken.
// Reset is synchronous and active low and returns the block to awaiting a header.
// A byte leaves the input register whenever the result register is free or
// being read, so a stalled result holds at most one byte in the input register.
module temperature_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_device_id,
    output logic [14:0] m_temperature
);
    import tfd_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        step;
    tfd_result_t res;

    assign step    = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

    tfd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .data_byte (in_byte_reg),
        .res       (res)
    );

    tfd_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (step),
        .res           (res),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_status      (m_status),
        .m_device_id   (m_device_id),
        .m_temperature (m_temperature)
    );

endmodule

### tb/tfd_checker.sv
// Checker for the temperature frame deframer: predicts readings from accepted bytes and compares.
module tfd_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [31:0] m_device_id,
    input  logic [14:0] m_temperature,
    input  logic        end_check,
    output int          fail_count,
    output int          pending
);
    import tfd_pkg::*;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] device_id;
        logic [14:0] temperature;
    } reading_t;

    localparam int PRINT_CAP = 100;

    reading_t    expected_readings[$];
    reading_t    want;
    logic [3:0]  frame_pos;
    logic [47:0] id_temp_bytes;
    logic [7:0]  tail_first_seen;
    logic [1:0]  trail_phase;
    logic        stopped;
    logic        leftovers_done;

    initial begin
        fail_count = 0;
        pending = 0;
        leftovers_done = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_CAP) $display("mismatch: %s", msg);
        fail_count++;
    endtask

    task automatic push_reading(input logic [1:0] st, input logic [31:0] id,
                                input logic [14:0] temp);
        reading_t r;
        r.status = st;
        r.device_id = id;
        r.temperature = temp;
        expected_readings.insert(expected_readings.size(), r);
    endtask

    task automatic halt_on_bad_header();
        stopped = 1'b1;
        frame_pos = POS_HEADER;
        trail_phase = PH_NONE;
        push_reading(ST_BADHEAD, 32'd0, 15'd0);
    endtask

    // Advances the frame parser by one received byte.
    task automatic parse_byte(input logic [7:0] b);
        logic [14:0] temp;
        if (stopped) return;
        if (trail_phase == PH_DD) begin
            trail_phase = PH_NONE;
            if (b != TAIL_SECOND) halt_on_bad_header();
            return;
        end
        if (trail_phase == PH_ENDED && b == TAIL_FIRST) begin
            trail_phase = PH_DD;
            return;
        end
        trail_phase = PH_NONE;
        if (frame_pos == POS_HEADER) begin
            if (b != HEADER_BYTE) halt_on_bad_header();
            else frame_pos = POS_UNUSED;
        end else if (frame_pos == POS_UNUSED) begin
            frame_pos = frame_pos + 4'd1;
        end else if (frame_pos <= POS_LAST_DATA) begin
            id_temp_bytes = {id_temp_bytes[39:0], b};
            frame_pos = frame_pos + 4'd1;
        end else if (frame_pos == POS_TAIL1) begin
            tail_first_seen = b;
            frame_pos = POS_TAIL2;
        end else begin
            // Last byte of the frame; anything past it counts as the last byte too.
            frame_pos = POS_HEADER;
            trail_phase = PH_ENDED;
            if (tail_first_seen != TAIL_FIRST || b != TAIL_SECOND) begin
                push_reading(ST_BADTAIL, 32'd0, 15'd0);
            end else begin
                temp = {7'd0, id_temp_bytes[15:8]} * TEMP_SCALE + {7'd0, id_temp_bytes[7:0]};
                push_reading(ST_GOOD, id_temp_bytes[47:16], temp);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            frame_pos = POS_HEADER;
            id_temp_bytes = '0;
            tail_first_seen = '0;
            trail_phase = PH_NONE;
            stopped = 1'b0;
            expected_readings.delete();
        end else begin
            if (s_valid && s_ready) parse_byte(s_data_byte);
            if (m_valid && m_ready) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status %0d id %h temp %0d",
                                              m_status, m_device_id, m_temperature));
                end else begin
                    want = expected_readings.pop_front();
                    if (m_status !== want.status)
                        report_mismatch($sformatf("status %0d, wanted %0d",
                                                  m_status, want.status));
                    if (m_device_id !== want.device_id)
                        report_mismatch($sformatf("device_id %h, wanted %h",
                                                  m_device_id, want.device_id));
                    if (m_temperature !== want.temperature)
                        report_mismatch($sformatf("temperature %0d, wanted %0d",
                                                  m_temperature, want.temperature));
                end
            end
            if (end_check && !leftovers_done) begin
                leftovers_done = 1'b1;
                foreach (expected_readings[i])
                    report_mismatch($sformatf("missing result status %0d id %h temp %0d",
                                              expected_readings[i].status,
                                              expected_readings[i].device_id,
                                              expected_readings[i].temperature));
            end
        end
        pending = expected_readings.size();
    end

endmodule

### tb/testbench.sv
// Top of the deframer testbench: clock, reset, byte stimulus, result back-pressure and verdict.
module testbench;
    import tfd_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_START   = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int STEADY_START = 900;
    localparam int STEADY_END   = 1300;
    localparam int FRAME_BYTES  = 1000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_device_id;
    logic [14:0] m_temperature;
    logic        end_check = 1'b0;
    int          fail_count;
    int          pending;

    bit          no_gaps = 1'b0;
    int          frame_bytes = 0;

    always #5 aclk = ~aclk;

    temperature_frame_deframer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_device_id   (m_device_id),
        .m_temperature (m_temperature)
    );

    tfd_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_device_id   (m_device_id),
        .m_temperature (m_temperature),
        .end_check     (end_check),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Offers one byte, with an occasional gap ahead of it, and returns once it is accepted.
    task automatic send_byte(input logic [7:0] b);
        if (!no_gaps && $urandom_range(99) < 16) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_frame(input logic [31:0] id, input logic [7:0] temp_hi,
                              input logic [7:0] temp_lo, input logic [7:0] tail1,
                              input logic [7:0] tail2);
        send_byte(HEADER_BYTE);
        send_byte(8'($urandom_range(255)));
        send_byte(id[31:24]);
        send_byte(id[23:16]);
        send_byte(id[15:8]);
        send_byte(id[7:0]);
        send_byte(temp_hi);
        send_byte(temp_lo);
        send_byte(tail1);
        send_byte(tail2);
        frame_bytes += 10;
    endtask

    // Stops offering bytes until every predicted result has come out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
    endtask

    initial begin : receiver
        int cyc;
        cyc = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) m_ready <= 1'b0;
            else if (cyc >= STEADY_START && cyc < STEADY_END) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(99) >= 24);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        int          frame_no;
        int          pick;
        logic [7:0]  t1;
        logic [7:0]  t2;
        logic [7:0]  b;
        frame_no = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Largest id and temperature, then a skipped tail pair, then a zero frame with a bad tail.
        send_frame(32'hFFFF_FFFF, 8'hFF, 8'hFF, TAIL_FIRST, TAIL_SECOND);
        send_byte(TAIL_FIRST);
        send_byte(TAIL_SECOND);
        send_frame(32'h0000_0000, 8'h00, 8'h00, TAIL_FIRST, 8'h00);

        // Well-formed frames with random content, some bad tails and optional skip pairs.
        while (frame_bytes < FRAME_BYTES) begin
            frame_no++;
            no_gaps = (frame_no >= 30 && frame_no < 50);
            if (frame_no == 70) wait_drained();
            pick = $urandom_range(99);
            t1 = TAIL_FIRST;
            t2 = TAIL_SECOND;
            if (pick >= 94) t1 = 8'($urandom_range(255));
            else if (pick >= 87) t2 = 8'($urandom_range(255));
            else if (pick >= 80) begin
                t1 = 8'($urandom_range(255));
                t2 = 8'($urandom_range(255));
            end
            send_frame($urandom, 8'($urandom_range(255)), 8'($urandom_range(255)), t1, t2);
            if ($urandom_range(99) < 30) begin
                send_byte(TAIL_FIRST);
                send_byte(TAIL_SECOND);
            end
        end
        no_gaps = 1'b0;

        // A bad header halts the block, so it can only come once, at the very end.
        pick = $urandom_range(2);
        if (pick == 0) begin
            do b = 8'($urandom_range(255)); while (b == HEADER_BYTE || b == TAIL_FIRST);
            send_byte(b);
        end else if (pick == 1) begin
            do b = 8'($urandom_range(255)); while (b == TAIL_SECOND);
            send_byte(TAIL_FIRST);
            send_byte(b);
        end else begin
            send_byte(TAIL_FIRST);
            send_byte(TAIL_SECOND);
            send_byte(TAIL_FIRST);
        end

        // The halted block must swallow everything, a valid header included.
        send_byte(HEADER_BYTE);
        repeat (7) send_byte(8'($urandom_range(255)));

        wait_drained();
        repeat (8) @(posedge aclk);
        end_check <= 1'b1;
        repeat (2) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/tfd_pkg.sv
hw/rtl/tfd_parser.sv
hw/rtl/tfd_out_stage.sv
hw/rtl/temperature_frame_deframer.sv
tb/tfd_checker.sv
tb/testbench.sv
